[src/esc_dec_pkg.sv]
// Shared types, codes and character helpers for the escape sequence decoder.
package esc_dec_pkg;

	localparam int CODE_W = 21;
	localparam int ACC_W  = 9;

	// decode modes
	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_ESC    = 3'd1;
	localparam logic [2:0] MODE_OCT    = 3'd2;
	localparam logic [2:0] MODE_HEX1   = 3'd3;
	localparam logic [2:0] MODE_HEX2   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNKNOWN   = 2'd1;
	localparam logic [1:0] ST_PREMATURE = 2'd2;
	localparam logic [1:0] ST_BADHEX    = 2'd3;

	localparam logic [CODE_W-1:0] CH_ZERO   = CODE_W'('h30);
	localparam logic [CODE_W-1:0] CH_SEVEN  = CODE_W'('h37);
	localparam logic [CODE_W-1:0] CH_NINE   = CODE_W'('h39);
	localparam logic [CODE_W-1:0] CH_LA     = CODE_W'('h61);
	localparam logic [CODE_W-1:0] CH_LF     = CODE_W'('h66);
	localparam logic [CODE_W-1:0] CH_UA     = CODE_W'('h41);
	localparam logic [CODE_W-1:0] CH_UF     = CODE_W'('h46);
	localparam logic [CODE_W-1:0] CH_X      = CODE_W'('h78);
	localparam logic [CODE_W-1:0] CH_B      = CODE_W'('h62);
	localparam logic [CODE_W-1:0] CH_N      = CODE_W'('h6E);
	localparam logic [CODE_W-1:0] CH_R      = CODE_W'('h72);
	localparam logic [CODE_W-1:0] CH_T      = CODE_W'('h74);
	localparam logic [CODE_W-1:0] CH_V      = CODE_W'('h76);
	localparam logic [CODE_W-1:0] CH_BSLASH = CODE_W'('h5C);
	localparam logic [CODE_W-1:0] CH_QUOTE  = CODE_W'('h27);
	localparam logic [CODE_W-1:0] CH_DQUOTE = CODE_W'('h22);
	localparam logic [CODE_W-1:0] CH_QMARK  = CODE_W'('h3F);

	localparam logic [4:0] HEX_NONE = 5'd16;

	typedef struct packed {
		logic [2:0]       mode;
		logic [1:0]       digits_left;
		logic [ACC_W-1:0] accum;
		logic             stopped;
		logic             dropping;
	} dec_state_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              eos;
		logic [1:0]        status;
	} dec_result_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} named_t;

	function automatic logic [4:0] hex_value(input logic [CODE_W-1:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) v = 5'(c - CH_ZERO);
		else if (c >= CH_LA && c <= CH_LF) v = 5'(c - CH_LA + CODE_W'(10));
		else if (c >= CH_UA && c <= CH_UF) v = 5'(c - CH_UA + CODE_W'(10));
		return v;
	endfunction

	function automatic named_t named_escape(input logic [CODE_W-1:0] c);
		named_t r;
		r.hit = 1'b1;
		case (c)
			CH_LA:     r.value = 8'd7;
			CH_B:      r.value = 8'd8;
			CH_LF:     r.value = 8'd12;
			CH_N:      r.value = 8'd10;
			CH_R:      r.value = 8'd13;
			CH_T:      r.value = 8'd9;
			CH_V:      r.value = 8'd11;
			CH_BSLASH: r.value = 8'd92;
			CH_QUOTE:  r.value = 8'd39;
			CH_DQUOTE: r.value = 8'd34;
			CH_QMARK:  r.value = 8'd63;
			default: begin
				r.hit   = 1'b0;
				r.value = 8'd0;
			end
		endcase
		return r;
	endfunction

endpackage

[src/esc_dec_core.sv]
// Next-state and result logic for one character of the escape decoder.
module esc_dec_core
	import esc_dec_pkg::*;
(
	input  dec_state_t        state,
	input  logic [CODE_W-1:0] char_code,
	input  logic              last_char,
	output dec_state_t        state_nx,
	output logic              res_valid,
	output dec_result_t       res
);

	named_t           named;
	logic [4:0]       hexv;
	logic             is_oct;
	logic [1:0]       dl_dec;
	logic [ACC_W-1:0] acc_oct;
	logic [ACC_W-1:0] acc_hex;
	dec_state_t       cleared;

	assign named   = named_escape(char_code);
	assign hexv    = hex_value(char_code);
	assign is_oct  = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
	assign dl_dec  = state.digits_left - 2'd1;
	assign acc_oct = {state.accum[ACC_W-4:0], char_code[2:0]};
	assign acc_hex = (hexv == HEX_NONE) ? state.accum
		: ACC_W'({state.accum[ACC_W-5:0], hexv[3:0]});

	always_comb begin
		cleared             = state;
		cleared.mode        = MODE_NORMAL;
		cleared.digits_left = 2'd0;
		cleared.accum       = '0;
		cleared.stopped     = 1'b0;

		state_nx   = state;
		res_valid  = 1'b0;
		res.code   = char_code;
		res.eos    = last_char;
		res.status = ST_OK;

		if (state.dropping) begin
			// swallow the rest of a failed string
			if (last_char) state_nx.dropping = 1'b0;
		end else begin
			case (state.mode)
				MODE_ESC: begin
					if (named.hit) begin
						state_nx  = cleared;
						res_valid = 1'b1;
						res.code  = CODE_W'(named.value);
					end else if (is_oct && !last_char) begin
						state_nx.mode        = MODE_OCT;
						state_nx.accum       = ACC_W'(char_code[2:0]);
						state_nx.digits_left = 2'd2;
						state_nx.stopped     = 1'b0;
					end else if (char_code == CH_X && !last_char) begin
						state_nx.mode  = MODE_HEX1;
						state_nx.accum = '0;
					end else begin
						res_valid  = 1'b1;
						res.status = (is_oct || char_code == CH_X) ? ST_PREMATURE
							: ST_UNKNOWN;
					end
				end
				MODE_OCT: begin
					state_nx.digits_left = dl_dec;
					if (!state.stopped && is_oct) state_nx.accum = acc_oct;
					else state_nx.stopped = 1'b1;
					if (dl_dec == 2'd0) begin
						res_valid = 1'b1;
						res.code  = CODE_W'(state_nx.accum[7:0]);
						state_nx  = cleared;
					end else if (last_char) begin
						res_valid  = 1'b1;
						res.status = ST_PREMATURE;
					end
				end
				MODE_HEX1: begin
					if (last_char) begin
						res_valid  = 1'b1;
						res.status = ST_PREMATURE;
					end else if (hexv == HEX_NONE) begin
						res_valid  = 1'b1;
						res.status = ST_BADHEX;
					end else begin
						state_nx.accum = ACC_W'(hexv);
						state_nx.mode  = MODE_HEX2;
					end
				end
				MODE_HEX2: begin
					res_valid = 1'b1;
					res.code  = CODE_W'(acc_hex[7:0]);
					state_nx  = cleared;
				end
				default: begin
					if (char_code == CH_BSLASH) begin
						if (last_char) begin
							res_valid  = 1'b1;
							res.status = ST_PREMATURE;
						end else begin
							state_nx      = cleared;
							state_nx.mode = MODE_ESC;
						end
					end else begin
						state_nx  = cleared;
						res_valid = 1'b1;
					end
				end
			endcase

			// any error ends the string and drops what is left of it
			if (res_valid && res.status != ST_OK) begin
				state_nx          = cleared;
				state_nx.dropping = !last_char;
				res.code          = '0;
				res.eos           = 1'b1;
			end
		end
	end

endmodule

[src/escape_sequence_decoder.sv]
// Top level of the escape sequence decoder: input stage, state and result register.
//
//  channel  dir  tdata bits                 tlast          tuser
//  s_*      in   char_code [20:0], zero pad last_char      -
//  m_*      out  out_code [20:0], zero pad  end_of_string  status [1:0]
//
// One character per cycle while m_tready allows; input stage, then result register.
// The limit is the combinational state update in esc_dec_core.
// A character that closes nothing (escape still open, or dropped) gives no beat.
// While m_tready is low the output register holds and one more beat waits in
// the input stage; arst_n clears both valids and returns to pass-through mode.
module escape_sequence_decoder
	import esc_dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] out_code, [23:21] zero
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic              item_valid_s1;
	logic [CODE_W-1:0] char_s1;
	logic              last_s1;
	dec_state_t        state_q;
	dec_state_t        state_nx;
	logic              res_valid;
	dec_result_t       res;
	logic              out_valid_q;
	dec_result_t       out_q;
	logic              advance;

	assign advance  = item_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[CODE_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	esc_dec_core u_core (
		.state     (state_q),
		.char_code (char_s1),
		.last_char (last_s1),
		.state_nx  (state_nx),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nx;
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.code};
	assign m_tlast  = out_q.eos;
	assign m_tuser  = out_q.status;

	a_drop_normal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dropping |-> state_q.mode == MODE_NORMAL)
		else $error("dropping while an escape is open");

	a_oct_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_OCT |-> state_q.digits_left != 2'd0)
		else $error("octal escape with no digits left");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata == 24'd0))
		else $error("error beat not final or not zero");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && m_tvalid && !m_tready) |=> $stable(state_q))
		else $error("state moved while output stalled");

endmodule

[sim/escape_sequence_decoder_tb.sv]
// Self-checking stream testbench for the escape sequence decoder.
module escape_sequence_decoder_tb
	import esc_dec_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD = 300;
	localparam logic [CODE_W-1:0] CH_LG = CODE_W'('h67);	// 'g', never a hex digit
	localparam logic [CODE_W-1:0] CH_LQ = CODE_W'('h71);	// 'q', never an escape
	localparam logic [CODE_W-1:0] NAMED_CHARS [11] = '{CH_LA, CH_B, CH_LF, CH_N, CH_R,
		CH_T, CH_V, CH_BSLASH, CH_QUOTE, CH_DQUOTE, CH_QMARK};

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} char_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;	// [20:0] char_code, [23:21] zero
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;	// [20:0] out_code, [23:21] zero
	logic        m_tlast;
	logic [1:0]  m_tuser;	// [1:0] status

	// decoder state as the predictor sees it
	logic [2:0]       dec_mode = MODE_NORMAL;
	logic [1:0]       oct_left = '0;
	logic [ACC_W-1:0] acc = '0;
	logic             oct_stopped = 1'b0;
	logic             drop_rest = 1'b0;

	char_beat_t  pending_chars[$];
	dec_result_t decoded_expected[$];
	char_beat_t  beat;
	dec_result_t next_res;
	dec_result_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int stall_trigger = 0;
	int stall_seen = 0;
	int chars_queued = 0;
	int strings_queued = 0;
	int chars_accepted = 0;
	int mismatch_count = 0;
	int status_count[4] = '{0, 0, 0, 0};

	escape_sequence_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [4:0] hex_digit(input logic [CODE_W-1:0] c);
		if (c inside {[CH_ZERO:CH_NINE]}) return 5'(c - CH_ZERO);
		if (c inside {[CH_LA:CH_LF]}) return 5'(c - CH_LA) + 5'd10;
		if (c inside {[CH_UA:CH_UF]}) return 5'(c - CH_UA) + 5'd10;
		return HEX_NONE;
	endfunction

	function automatic bit escape_value(input logic [CODE_W-1:0] c, output logic [7:0] v);
		v = 8'd0;
		case (c)
			CH_LA:     v = 8'd7;
			CH_B:      v = 8'd8;
			CH_LF:     v = 8'd12;
			CH_N:      v = 8'd10;
			CH_R:      v = 8'd13;
			CH_T:      v = 8'd9;
			CH_V:      v = 8'd11;
			CH_BSLASH: v = 8'd92;
			CH_QUOTE:  v = 8'd39;
			CH_DQUOTE: v = 8'd34;
			CH_QMARK:  v = 8'd63;
			default:   return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void clear_escape_state();
		dec_mode = MODE_NORMAL;
		oct_left = '0;
		acc = '0;
		oct_stopped = 1'b0;
	endfunction

	// An error closes the string; drop the rest unless this was its last character.
	function automatic bit flag_error(output dec_result_t r, input logic [1:0] st,
			input logic last);
		r = '{code: '0, eos: 1'b1, status: st};
		clear_escape_state();
		drop_rest = !last;
		return 1'b1;
	endfunction

	function automatic bit decode_char(input logic [CODE_W-1:0] c, input logic last,
			output dec_result_t r);
		logic [4:0] hv;
		logic [7:0] nv;
		r = '0;
		if (drop_rest) begin
			if (last) drop_rest = 1'b0;
			return 1'b0;
		end
		case (dec_mode)
			MODE_ESC: begin
				if (escape_value(c, nv)) begin
					clear_escape_state();
					r = '{code: CODE_W'(nv), eos: last, status: ST_OK};
					return 1'b1;
				end
				if (c inside {[CH_ZERO:CH_SEVEN]}) begin
					if (last) return flag_error(r, ST_PREMATURE, last);
					dec_mode = MODE_OCT;
					acc = ACC_W'(c - CH_ZERO);
					oct_left = 2'd2;
					oct_stopped = 1'b0;
					return 1'b0;
				end
				if (c == CH_X) begin
					if (last) return flag_error(r, ST_PREMATURE, last);
					dec_mode = MODE_HEX1;
					acc = '0;
					return 1'b0;
				end
				return flag_error(r, ST_UNKNOWN, last);
			end
			MODE_OCT: begin
				if (!oct_stopped && c inside {[CH_ZERO:CH_SEVEN]})
					acc = {acc[ACC_W-4:0], 3'(c - CH_ZERO)};
				else
					oct_stopped = 1'b1;
				oct_left = oct_left - 2'd1;
				if (oct_left == 2'd0) begin
					nv = acc[7:0];
					clear_escape_state();
					r = '{code: CODE_W'(nv), eos: last, status: ST_OK};
					return 1'b1;
				end
				if (last) return flag_error(r, ST_PREMATURE, last);
				return 1'b0;
			end
			MODE_HEX1: begin
				if (last) return flag_error(r, ST_PREMATURE, last);
				hv = hex_digit(c);
				if (hv == HEX_NONE) return flag_error(r, ST_BADHEX, last);
				acc = ACC_W'(hv);
				dec_mode = MODE_HEX2;
				return 1'b0;
			end
			MODE_HEX2: begin
				hv = hex_digit(c);
				if (hv != HEX_NONE) acc = {acc[ACC_W-5:0], hv[3:0]};
				nv = acc[7:0];
				clear_escape_state();
				r = '{code: CODE_W'(nv), eos: last, status: ST_OK};
				return 1'b1;
			end
			default: begin
				if (c == CH_BSLASH) begin
					if (last) return flag_error(r, ST_PREMATURE, last);
					clear_escape_state();
					dec_mode = MODE_ESC;
					return 1'b0;
				end
				clear_escape_state();
				r = '{code: c, eos: last, status: ST_OK};
				return 1'b1;
			end
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] any_char();
		case ($urandom_range(3))
			0:       return CODE_W'($urandom_range(126, 32));
			1:       return CODE_W'($urandom_range(127));
			2:       return CODE_W'($urandom_range(255));
			default: return CODE_W'($urandom_range(1114111));
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] hex_char();
		case ($urandom_range(2))
			0:       return CH_ZERO + CODE_W'($urandom_range(9));
			1:       return CH_LA + CODE_W'($urandom_range(5));
			default: return CH_UA + CODE_W'($urandom_range(5));
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] oct_char();
		return CH_ZERO + CODE_W'($urandom_range(7));
	endfunction

	task automatic queue_string(input logic [CODE_W-1:0] s[$]);
		for (int k = 0; k < s.size(); k++)
			pending_chars.insert(pending_chars.size(),
				char_beat_t'{code: s[k], last: k == s.size() - 1});
		chars_queued += s.size();
		strings_queued++;
	endtask

	// Mostly well-formed escapes; a broken string gets one bad escape or ends inside one.
	task automatic add_string(input bit broken);
		logic [CODE_W-1:0] s[$];
		logic [CODE_W-1:0] c;
		int nseg;
		int bad_at;
		int sel;
		nseg = $urandom_range(8, 1);
		bad_at = broken ? int'($urandom_range(nseg)) : -1;
		for (int k = 0; k < nseg; k++) begin
			sel = $urandom_range(99);
			if (k == bad_at) begin
				s.insert(s.size(), CH_BSLASH);
				if (sel < 50) begin
					s.insert(s.size(), sel < 25 ? CH_LQ : any_char());
				end else begin
					s.insert(s.size(), CH_X);
					s.insert(s.size(), sel < 75 ? CH_LG : any_char());
				end
			end else if (sel < 40) begin
				c = any_char();
				s.insert(s.size(), c == CH_BSLASH ? CH_QMARK : c);
			end else if (sel < 55) begin
				s.insert(s.size(), CH_BSLASH);
				s.insert(s.size(), NAMED_CHARS[$urandom_range(10)]);
			end else if (sel < 75) begin
				s.insert(s.size(), CH_BSLASH);
				s.insert(s.size(), oct_char());
				s.insert(s.size(), $urandom_range(4) == 0 ? any_char() : oct_char());
				s.insert(s.size(), $urandom_range(4) == 0 ? any_char() : oct_char());
			end else if (sel < 95) begin
				s.insert(s.size(), CH_BSLASH);
				s.insert(s.size(), CH_X);
				s.insert(s.size(), hex_char());
				s.insert(s.size(), $urandom_range(3) == 0 ? any_char() : hex_char());
			end else begin
				s.insert(s.size(), CODE_W'($urandom_range(1114111)));
			end
		end
		if (bad_at == nseg) begin
			s.insert(s.size(), CH_BSLASH);
			case ($urandom_range(4))
				0: ;
				1: s.insert(s.size(), oct_char());
				2: begin
					s.insert(s.size(), oct_char());
					s.insert(s.size(), any_char());
				end
				3: s.insert(s.size(), CH_X);
				default: begin
					s.insert(s.size(), CH_X);
					s.insert(s.size(), any_char());
				end
			endcase
		end
		queue_string(s);
	endtask

	task automatic fill_random(input int n);
		int target;
		target = chars_queued + n;
		while (chars_queued < target) add_string($urandom_range(99) < 15);
	endtask

	task automatic drain();
		while (pending_chars.size() != 0 || s_tvalid || decoded_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, msg);
	endtask

	// Predict on each accepted beat, then offer the next pending character.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				chars_accepted++;
				if (decode_char(s_tdata[CODE_W-1:0], s_tlast, next_res))
					decoded_expected.insert(decoded_expected.size(), next_res);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat = pending_chars.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, beat.code};
					s_tlast <= beat.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (stall_seen != stall_trigger) begin
			stall_seen <= stall_trigger;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_expected.size() == 0) begin
				note_mismatch($sformatf("unexpected beat code %0h eos %0b status %0d",
					m_tdata, m_tlast, m_tuser));
			end else begin
				want = decoded_expected.pop_front();
				status_count[want.status]++;
				if (m_tdata !== {3'b000, want.code} || m_tlast !== want.eos ||
						m_tuser !== want.status)
					note_mismatch($sformatf(
						"expected code %0h eos %0b status %0d, got %0h eos %0b status %0d",
						want.code, want.eos, want.status, m_tdata, m_tlast, m_tuser));
			end
		end
	end

	initial begin
		logic [CODE_W-1:0] ds[$];
		send_idle_pct = 26;
		recv_idle_pct = 52;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// plain extremes, then a named escape closing the string
		ds = {CODE_W'(0), CODE_W'('h10FFFF), CH_BSLASH, CH_N};
		queue_string(ds);
		// octal value wraps mod 256
		ds = {CH_BSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN};
		queue_string(ds);
		// octal run stopped by a wide code point whose low byte is a digit
		ds = {CH_BSLASH, CH_ZERO, CODE_W'('h10030), CH_SEVEN};
		queue_string(ds);
		// hex with one digit only
		ds = {CH_BSLASH, CH_X, CH_UF, CH_LG};
		queue_string(ds);
		// unknown escape, rest dropped
		ds = {CH_BSLASH, CH_LQ, CH_ZERO, CH_LG};
		queue_string(ds);
		// bad hex digit, rest dropped
		ds = {CH_BSLASH, CH_X, CH_LG, CH_ZERO};
		queue_string(ds);
		// end inside escapes; early end wins over bad hex digit
		ds = {CH_BSLASH, CH_X, CH_LG};
		queue_string(ds);
		ds = {CH_BSLASH, CH_ZERO + CODE_W'(5), CH_ZERO + CODE_W'(6)};
		queue_string(ds);
		ds = {CH_BSLASH};
		queue_string(ds);

		fill_random(180);
		stall_trigger++;
		drain();

		send_idle_pct = 52;
		recv_idle_pct = 26;
		fill_random(180);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_random(190);
		stall_trigger++;
		drain();
		repeat (10) @(negedge clk);

		$display("Decoded %0d characters in %0d strings under three idle patterns",
			chars_accepted, strings_queued);
		$display("and two long output stalls: %0d ok, %0d unknown, %0d early end, %0d bad hex.",
			status_count[ST_OK], status_count[ST_UNKNOWN], status_count[ST_PREMATURE],
			status_count[ST_BADHEX]);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", decoded_expected.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
